/* rtl/cdsd_pkg.sv */
package cdsd_pkg;

  localparam int RND_W   = 32;
  localparam int DIGIT_W = 4;   // dividend bits retired per cycle by the remainder unit
  localparam int SUIT_W  = 2;
  localparam int RANK_W  = 4;
  localparam int ENTRY_W = SUIT_W + RANK_W;
  localparam int LEFT_W  = 6;
  localparam int STEP_W  = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    OP_REBUILD = 2'd0,
    OP_SHUFFLE = 2'd1,
    OP_DRAW    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER      = 3'd0,
    COND_ALWAYS     = 3'd1,
    COND_SHUF_END   = 3'd2,
    COND_DRAW_EMPTY = 3'd3,
    COND_MOD_BUSY   = 3'd4,
    COND_OUT_BUSY   = 3'd5
  } cond_t;

  typedef enum logic [1:0] {
    RD_SHUF = 2'd0,
    RD_REM  = 2'd1,
    RD_DRAW = 2'd2
  } rsel_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_I_B  = 2'd1,
    WR_J_A  = 2'd2
  } wsel_t;

  typedef struct packed {
    logic  take_in;
    cond_t cond;
    step_t target;
    logic  mod_start;
    rsel_t rd_sel;
    logic  latch_a;
    logic  latch_b;
    wsel_t wr_sel;
    logic  clr_deck;
    logic  inc_shuf;
    logic  inc_draw;
    logic  set_card;
    logic  emit;
  } ctrl_t;

  typedef struct packed {
    logic in_accept;
    op_t  op;
    logic shuf_end;
    logic draw_empty;
    logic mod_busy;
    logic out_busy;
  } stat_t;

  // microprogram step addresses
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_REBUILD  = 4'd1;
  localparam step_t S_SHUF     = 4'd2;
  localparam step_t S_LATCH_A  = 4'd3;
  localparam step_t S_MOD_WAIT = 4'd4;
  localparam step_t S_LATCH_B  = 4'd5;
  localparam step_t S_WR_I     = 4'd6;
  localparam step_t S_WR_J     = 4'd7;
  localparam step_t S_DRAW     = 4'd8;
  localparam step_t S_TAKE     = 4'd9;
  localparam step_t S_OUT_WAIT = 4'd10;
  localparam step_t S_EMIT     = 4'd11;

  function automatic step_t dispatch(op_t op);
    step_t s;
    case (op)
      OP_REBUILD: s = S_REBUILD;
      OP_SHUFFLE: s = S_SHUF;
      OP_DRAW:    s = S_DRAW;
      default:    s = S_OUT_WAIT;
    endcase
    return s;
  endfunction

  function automatic ctrl_t ucode(step_t pc);
    ctrl_t w;
    w = '0;
    w.cond   = COND_NEVER;
    w.rd_sel = RD_SHUF;
    w.wr_sel = WR_NONE;
    w.target = S_IDLE;
    case (pc)
      S_IDLE: begin
        w.take_in = 1'b1;
      end
      S_REBUILD: begin
        w.clr_deck = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = S_OUT_WAIT;
      end
      S_SHUF: begin
        w.mod_start = 1'b1;
        w.rd_sel    = RD_SHUF;
        w.cond      = COND_SHUF_END;
        w.target    = S_OUT_WAIT;
      end
      S_LATCH_A: begin
        w.latch_a = 1'b1;
      end
      S_MOD_WAIT: begin
        w.rd_sel = RD_REM;
        w.cond   = COND_MOD_BUSY;
        w.target = S_MOD_WAIT;
      end
      S_LATCH_B: begin
        w.latch_b = 1'b1;
      end
      S_WR_I: begin
        w.wr_sel = WR_I_B;
      end
      S_WR_J: begin
        w.wr_sel   = WR_J_A;
        w.inc_shuf = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = S_OUT_WAIT;
      end
      S_DRAW: begin
        w.rd_sel = RD_DRAW;
        w.cond   = COND_DRAW_EMPTY;
        w.target = S_OUT_WAIT;
      end
      S_TAKE: begin
        w.set_card = 1'b1;
        w.inc_draw = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        w.cond   = COND_OUT_BUSY;
        w.target = S_OUT_WAIT;
      end
      S_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/card_deck_shuffle_deal_unit.sv */
// Card deck unit: holds DECK_SIZE cards (suit, rank) in a RAM plus a draw
// position and a shuffle position. operation 0 rebuilds the ordered deck
// (suit-major) and zeroes both positions, 1 performs one forward Fisher-Yates
// step (swap entry i with entry random_value mod (i+1)), 2 deals the card at
// the draw position. Each request gives exactly one result; card_valid marks
// a dealt card, shuffle_done and cards_left show state after the request.
// Control is a 12-step microprogram. A shuffle step uses the remainder unit,
// which retires 4 bits of the 32-bit random word per cycle, plus the
// read-read-write-write swap through the RAM. A shuffle past the end skips
// the remainder unit and the swap. One request is in flight at a time; the
// next is taken while a result still waits on out_ready. Rebuild clears
// per-entry valid bits together, so no clearing pass runs after reset.
module card_deck_shuffle_deal_unit
  import cdsd_pkg::*;
  #(
    parameter int SUIT_COUNT = 4,
    parameter int RANK_COUNT = 15,
    parameter int DECK_SIZE  = 60
  )
  (
    input  logic              clk,
    input  logic              rst,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [RND_W-1:0]  random_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SUIT_W-1:0] suit,
    output logic [RANK_W-1:0] rank,
    output logic              card_valid,
    output logic              shuffle_done,
    output logic [LEFT_W-1:0] cards_left
  );

  localparam int AW = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
  localparam int PW = $clog2(DECK_SIZE + 1);
  localparam logic [PW-1:0] DECK_END = PW'(DECK_SIZE);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_accept;

  logic [PW-1:0]      shuf_pos;
  logic [PW-1:0]      draw_pos;
  logic [RND_W-1:0]   rnd;
  logic [DECK_SIZE-1:0] entry_written;

  logic [AW-1:0]      raddr;
  logic [AW-1:0]      raddr_q;
  logic               rwritten_q;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] entry_data;
  logic [ENTRY_W-1:0] ordered_tab [DECK_SIZE];

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] ent_a;
  logic [ENTRY_W-1:0] ent_b;

  logic               mod_go;
  logic               mod_busy;
  logic [PW-1:0]      mod_rem;

  logic [SUIT_W-1:0]  card_suit;
  logic [RANK_W-1:0]  card_rank;
  logic               card_hit;

  assign in_ready  = ctrl.take_in;
  assign in_accept = in_valid && in_ready;

  assign stat.in_accept  = in_accept;
  assign stat.op         = op_t'(operation);
  assign stat.shuf_end   = shuf_pos == DECK_END;
  assign stat.draw_empty = draw_pos == DECK_END;
  assign stat.mod_busy   = mod_busy;
  assign stat.out_busy   = out_valid && !out_ready;

  // a shuffle past the end skips the remainder unit
  assign mod_go = ctrl.mod_start && !stat.shuf_end;

  cdsd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  cdsd_modu #(.DW(PW)) u_modu (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_go),
    .dividend  (rnd),
    .divisor   (shuf_pos + 1'b1),
    .busy      (mod_busy),
    .remainder (mod_rem)
  );

  // reset contents of each entry, fixed at elaboration
  for (genvar k = 0; k < DECK_SIZE; k++) begin : g_ordered
    localparam logic [SUIT_W-1:0] SV = SUIT_W'(k / RANK_COUNT);
    localparam logic [RANK_W-1:0] RV = RANK_W'(k % RANK_COUNT);
    assign ordered_tab[k] = (k < SUIT_COUNT * RANK_COUNT) ? {SV, RV} : '0;
  end

  always_comb begin
    case (ctrl.rd_sel)
      RD_SHUF: raddr = shuf_pos[AW-1:0];
      RD_REM:  raddr = mod_rem[AW-1:0];
      RD_DRAW: raddr = draw_pos[AW-1:0];
      default: raddr = shuf_pos[AW-1:0];
    endcase
  end

  always_comb begin
    case (ctrl.wr_sel)
      WR_I_B: begin
        we    = 1'b1;
        waddr = shuf_pos[AW-1:0];
        wdata = ent_b;
      end
      WR_J_A: begin
        we    = 1'b1;
        waddr = mod_rem[AW-1:0];
        wdata = ent_a;
      end
      default: begin
        we    = 1'b0;
        waddr = shuf_pos[AW-1:0];
        wdata = ent_a;
      end
    endcase
  end

  cdsd_ram #(.WIDTH(ENTRY_W), .DEPTH(DECK_SIZE), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // entries not written since rebuild read as the ordered deck
  assign entry_data = rwritten_q ? ram_rdata : ordered_tab[raddr_q];

  always_ff @(posedge clk) begin
    raddr_q    <= raddr;
    rwritten_q <= entry_written[raddr];
    if (in_accept) begin
      rnd <= random_value;
    end
    if (ctrl.latch_a) begin
      ent_a <= entry_data;
    end
    if (ctrl.latch_b) begin
      ent_b <= entry_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shuf_pos      <= '0;
      draw_pos      <= '0;
      entry_written <= '0;
      card_suit     <= '0;
      card_rank     <= '0;
      card_hit      <= 1'b0;
      out_valid     <= 1'b0;
      suit          <= '0;
      rank          <= '0;
      card_valid    <= 1'b0;
      shuffle_done  <= 1'b0;
      cards_left    <= '0;
    end else begin
      if (ctrl.clr_deck) begin
        shuf_pos      <= '0;
        draw_pos      <= '0;
        entry_written <= '0;
      end
      if (we) begin
        entry_written[waddr] <= 1'b1;
      end
      if (ctrl.inc_shuf) begin
        shuf_pos <= shuf_pos + 1'b1;
      end
      if (ctrl.inc_draw) begin
        draw_pos <= draw_pos + 1'b1;
      end
      if (in_accept) begin
        card_suit <= '0;
        card_rank <= '0;
        card_hit  <= 1'b0;
      end else if (ctrl.set_card) begin
        card_suit <= entry_data[ENTRY_W-1 -: SUIT_W];
        card_rank <= entry_data[RANK_W-1:0];
        card_hit  <= 1'b1;
      end
      if (ctrl.emit) begin
        out_valid    <= 1'b1;
        suit         <= card_suit;
        rank         <= card_rank;
        card_valid   <= card_hit;
        shuffle_done <= shuf_pos == DECK_END;
        cards_left   <= LEFT_W'(DECK_END - draw_pos);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_draw_in_range: assert property (@(posedge clk) disable iff (rst)
    draw_pos <= DECK_END && shuf_pos <= DECK_END)
    else $error("deck position beyond deck size");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> waddr < AW'(DECK_SIZE - 1) || waddr == AW'(DECK_SIZE - 1))
    else $error("swap write outside the deck");

  a_emit_into_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> !out_valid)
    else $error("result emitted over an untaken result");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    mod_go |-> !mod_busy)
    else $error("remainder unit restarted while busy");
`endif

endmodule

/* rtl/cdsd_ram.sv */
module cdsd_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
  )
  (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cdsd_modu.sv */
module cdsd_modu
  import cdsd_pkg::*;
  #(
    parameter int DW = 7
  )
  (
    input  logic             clk,
    input  logic             rst,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [DW-1:0]    divisor,
    output logic             busy,
    output logic [DW-1:0]    remainder
  );

  localparam int STEPS = RND_W / DIGIT_W;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [RND_W-1:0] bits;
  logic [DW-1:0]    div;
  logic [CW-1:0]    cnt;
  logic [DW-1:0]    rem_next;
  logic [DW-1:0]    remainder_q;

  assign remainder = remainder_q;

  // restoring remainder, DIGIT_W dividend bits per cycle, msb first
  always_comb begin
    logic [DW:0] t;
    rem_next = remainder_q;
    for (int k = 0; k < DIGIT_W; k++) begin
      t = {rem_next, bits[RND_W-1-k]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      rem_next = t[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bits        <= dividend;
      div         <= divisor;
      remainder_q <= '0;
    end else if (busy) begin
      bits        <= bits << DIGIT_W;
      remainder_q <= rem_next;
    end
  end

endmodule

/* rtl/cdsd_seq.sv */
module cdsd_seq
  import cdsd_pkg::*;
  (
    input  logic  clk,
    input  logic  rst,
    input  stat_t stat,
    output ctrl_t ctrl
  );

  step_t pc;
  step_t pc_next;
  logic  cond_hit;

  assign ctrl = ucode(pc);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:      cond_hit = 1'b0;
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_SHUF_END:   cond_hit = stat.shuf_end;
      COND_DRAW_EMPTY: cond_hit = stat.draw_empty;
      COND_MOD_BUSY:   cond_hit = stat.mod_busy;
      COND_OUT_BUSY:   cond_hit = stat.out_busy;
      default:         cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (ctrl.take_in) begin
      pc_next = stat.in_accept ? dispatch(stat.op) : pc;
    end else if (cond_hit) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= S_EMIT)
    else $error("step counter left the program");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> ctrl.take_in)
    else $error("sequencer did not return to idle after emitting a result");

  a_wait_until_done: assert property (@(posedge clk) disable iff (rst)
    (pc == S_MOD_WAIT && stat.mod_busy) |=> pc == S_MOD_WAIT)
    else $error("left remainder wait while unit still busy");
`endif

endmodule
